FILE: src/cwat_pkg.sv
// Shared types and codes for the card whitelist access table.
`timescale 1ns / 1ps

package cwat_pkg;

    localparam int ID_W     = 40;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 5;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_ADD     = 3'd0;
    localparam t_op OP_DEL     = 3'd1;
    localparam t_op OP_COUNT   = 3'd2;
    localparam t_op OP_PRESENT = 3'd3;
    localparam t_op OP_ABSENT  = 3'd4;

    localparam t_status STAT_ADDED    = 4'd0;
    localparam t_status STAT_DELETED  = 4'd1;
    localparam t_status STAT_FULL     = 4'd2;
    localparam t_status STAT_EXISTS   = 4'd3;
    localparam t_status STAT_NOTFOUND = 4'd4;
    localparam t_status STAT_COUNT    = 4'd5;
    localparam t_status STAT_GRANTED  = 4'd6;
    localparam t_status STAT_DENIED   = 4'd7;
    localparam t_status STAT_RELEASED = 4'd8;
    localparam t_status STAT_NOCHANGE = 4'd9;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] card_id;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
        logic               presence_light;
        logic               grant_light;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_run;
        logic shift_start;
        logic shift_run;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_scan;
        logic del_op;
        logic scan_hit;
        logic walk_end;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/cwat_stream_if.sv
// Valid/ready stream channel carrying one payload word.
`timescale 1ns / 1ps

interface cwat_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cwat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cwat_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cwat_ctrl.sv
// Controller state machine: sequences load, table walks and result commit.
`timescale 1ns / 1ps

module cwat_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cwat_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output cwat_pkg::t_ctl_cmd o_cmd
);

    cwat_pkg::t_state r_state;
    cwat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cwat_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cwat_pkg::S_EXEC;
                end
            end
            cwat_pkg::S_EXEC: begin
                n_state = i_stat.need_scan ? cwat_pkg::S_SCAN : cwat_pkg::S_FINISH;
            end
            cwat_pkg::S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = i_stat.del_op ? cwat_pkg::S_SHIFT : cwat_pkg::S_FINISH;
                end else if (i_stat.walk_end) begin
                    n_state = cwat_pkg::S_FINISH;
                end
            end
            cwat_pkg::S_SHIFT: begin
                if (i_stat.walk_end) begin
                    n_state = cwat_pkg::S_FINISH;
                end
            end
            cwat_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = cwat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cwat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            cwat_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            cwat_pkg::S_EXEC: begin
                o_cmd.scan_start = i_stat.need_scan;
            end
            cwat_pkg::S_SCAN: begin
                o_cmd.scan_run    = 1'b1;
                o_cmd.shift_start = i_stat.scan_hit && i_stat.del_op;
            end
            cwat_pkg::S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
            end
            cwat_pkg::S_FINISH: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/cwat_dp.sv
// Datapath: ID table memory, walk pointers, card state and output register.
`timescale 1ns / 1ps

module cwat_dp #(
    parameter int MAX_IDS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cwat_pkg::t_ctl_cmd  i_cmd,
    input  cwat_pkg::t_in_word  i_in_data,
    input  logic                i_out_ready,
    output cwat_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output cwat_pkg::t_out_word o_out_data
);

    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IDS);

    // item registers
    cwat_pkg::t_op             r_op;
    logic [cwat_pkg::ID_W-1:0] r_id;
    logic                      r_found;
    logic                      n_found;

    // architectural state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_held;
    logic             n_held;
    logic             r_granted;
    logic             n_granted;

    // walk pointers
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] n_rd_idx;
    logic             r_rd_v;
    logic             n_rd_v;

    // output register
    logic                r_out_valid;
    logic                n_out_valid;
    cwat_pkg::t_out_word r_out_data;
    cwat_pkg::t_out_word n_out_data;

    logic                      w_issue;
    logic                      w_walk;
    logic                      w_hit;
    logic                      w_full;
    logic                      w_add_wr;
    logic [CNT_W-1:0]          w_prev;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic [cwat_pkg::ID_W-1:0] w_wdata;
    logic [cwat_pkg::ID_W-1:0] w_rdata;
    cwat_pkg::t_status         w_status;

    cwat_ram #(
        .WIDTH (cwat_pkg::ID_W),
        .DEPTH (MAX_IDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_walk && w_issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_issue  = r_idx < r_count;
        w_walk   = i_cmd.scan_run || i_cmd.shift_run;
        w_hit    = r_rd_v && (w_rdata == r_id);
        w_full   = r_count >= CNT_MAX;
        w_prev   = r_rd_idx - 1'b1;
        w_add_wr = i_cmd.commit && (r_op == cwat_pkg::OP_ADD) && !w_full && !r_found;

        // move the entry read last cycle down by one slot, or append an added ID at the table end
        w_we    = (i_cmd.shift_run && r_rd_v) || w_add_wr;
        w_waddr = i_cmd.shift_run ? w_prev[IDX_W-1:0] : r_count[IDX_W-1:0];
        w_wdata = i_cmd.shift_run ? w_rdata : r_id;
    end

    always_comb begin
        n_idx    = r_idx;
        n_rd_v   = r_rd_v;
        n_rd_idx = r_rd_idx;
        n_found  = r_found;
        if (i_cmd.load) begin
            n_found = 1'b0;
        end
        if (i_cmd.scan_run && w_hit) begin
            n_found = 1'b1;
        end
        if (i_cmd.shift_start) begin
            n_idx  = r_rd_idx + 1'b1;
            n_rd_v = 1'b0;
        end else if (i_cmd.scan_start) begin
            n_idx  = '0;
            n_rd_v = 1'b0;
        end else if (w_walk) begin
            n_rd_v   = w_issue;
            n_rd_idx = r_idx;
            if (w_issue) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_held    = r_held;
        n_granted = r_granted;
        w_status  = cwat_pkg::STAT_NOCHANGE;
        case (r_op)
            cwat_pkg::OP_ADD: begin
                if (w_full) begin
                    w_status = cwat_pkg::STAT_FULL;
                end else if (r_found) begin
                    w_status = cwat_pkg::STAT_EXISTS;
                end else begin
                    w_status = cwat_pkg::STAT_ADDED;
                    n_count  = r_count + 1'b1;
                end
            end
            cwat_pkg::OP_DEL: begin
                if (r_found) begin
                    w_status = cwat_pkg::STAT_DELETED;
                    n_count  = r_count - 1'b1;
                end else begin
                    w_status = cwat_pkg::STAT_NOTFOUND;
                end
            end
            cwat_pkg::OP_COUNT: begin
                w_status = cwat_pkg::STAT_COUNT;
            end
            cwat_pkg::OP_PRESENT: begin
                if (!r_held) begin
                    n_held    = 1'b1;
                    n_granted = r_found;
                    w_status  = r_found ? cwat_pkg::STAT_GRANTED : cwat_pkg::STAT_DENIED;
                end
            end
            cwat_pkg::OP_ABSENT: begin
                if (r_held) begin
                    n_held    = 1'b0;
                    n_granted = 1'b0;
                    w_status  = cwat_pkg::STAT_RELEASED;
                end
            end
            default: begin
                w_status = cwat_pkg::STAT_NOCHANGE;
            end
        endcase
        if (!i_cmd.commit) begin
            n_count   = r_count;
            n_held    = r_held;
            n_granted = r_granted;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (i_cmd.commit) begin
            n_out_valid                = 1'b1;
            n_out_data.status          = w_status;
            n_out_data.entry_count     = cwat_pkg::COUNT_W'(n_count);
            n_out_data.presence_light  = n_held;
            n_out_data.grant_light     = n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_held      <= 1'b0;
            r_granted   <= 1'b0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_held      <= n_held;
            r_granted   <= n_granted;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in_data.op;
            r_id <= i_in_data.card_id;
        end
        r_found    <= n_found;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_out_data <= n_out_data;
    end

    always_comb begin
        o_stat.need_scan = ((r_op == cwat_pkg::OP_ADD) && !w_full)
                        || (r_op == cwat_pkg::OP_DEL)
                        || ((r_op == cwat_pkg::OP_PRESENT) && !r_held);
        o_stat.del_op    = r_op == cwat_pkg::OP_DEL;
        o_stat.scan_hit  = w_hit;
        o_stat.walk_end  = !r_rd_v && !w_issue;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: src/card_whitelist_access_table.sv
// Top level of the card whitelist access table.
`timescale 1ns / 1ps

// Holds up to MAX_IDS 40-bit card IDs in a table memory with one registered read port and
// returns one result word per input word. Lookups walk the table one entry per cycle; an
// add, a card-present word or a delete stops its walk early when the ID turns up. A delete
// that finds its ID stops its scan at the match, then moves the entries above it down one
// per cycle. Count queries, card-absent words, adds to a full table and card-present words
// while a card is held make no walk. One word is worked on at a time; the output register
// lets the next word in while a result waits, and that word then holds at its commit until
// the waiting result is taken. The table needs no clearing after reset.
module card_whitelist_access_table #(
    parameter int MAX_IDS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cwat_stream_if.sink          i_in,
    cwat_stream_if.source        o_out
);

    cwat_pkg::t_ctl_cmd  w_cmd;
    cwat_pkg::t_dp_stat  w_stat;
    logic                w_in_ready;
    logic                w_out_valid;
    cwat_pkg::t_out_word w_out_data;

    cwat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    cwat_dp #(
        .MAX_IDS (MAX_IDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in.data),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_out_data  (w_out_data)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

endmodule

FILE: src/cwat_checker.sv
// Port-level checker for the card whitelist access table, bound to the top level.
`timescale 1ns / 1ps

module cwat_checker #(
    parameter int MAX_IDS = 20
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cwat_pkg::t_out_word i_out_data
);

    // a stalled result word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // one word in work at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after accept");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data.grant_light || i_out_data.presence_light)
        else $error("grant light without presence light");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (MAX_IDS > 31) || (32'(i_out_data.entry_count) <= 32'(MAX_IDS)))
        else $error("entry count above table size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == cwat_pkg::STAT_RELEASED)
        |-> !i_out_data.presence_light && !i_out_data.grant_light)
        else $error("lights still on after release");

endmodule

bind card_whitelist_access_table cwat_checker #(
    .MAX_IDS (MAX_IDS)
) u_cwat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
